[design/swm_pkg.sv]
// Shared types and constants for the sliding window maximum block.
// Used by swm_cell and sliding_window_max; depends on nothing else.
package swm_pkg;

  // Width of the window size register and its value after reset.
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd1;

  // Per-cycle commands broadcast from the top level to every cell.
  typedef struct packed {
    logic step;   // an input word is accepted this cycle
    logic flush;  // the word restarts the sequence, so the queue counts as empty
    logic drop;   // the head has left the window and the queue shifts toward the head
    logic wipe;   // a window size write empties the queue
  } swm_ctl_t;

endpackage

[design/swm_cell.sv]
// One queue slot of the monotonic queue: value, arrival position and a valid bit.
// Depends on swm_pkg for the command struct; instantiated in a row by sliding_window_max.
module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int POS_W        = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  swm_ctl_t                       ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] new_value,
  input  logic [POS_W-1:0]               new_pos,
  input  logic                           nb_valid,   // slot one step toward the tail
  input  logic signed [SAMPLE_WIDTH-1:0] nb_value,
  input  logic [POS_W-1:0]               nb_pos,
  input  logic                           prev_kept,  // slot toward the head survives
  output logic                           valid,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic [POS_W-1:0]               pos,
  output logic                           kept,
  output logic signed [SAMPLE_WIDTH-1:0] value_nxt
);

  logic                           valid_r;
  logic signed [SAMPLE_WIDTH-1:0] value_r;
  logic [POS_W-1:0]               pos_r;
  logic                           valid_nxt;
  logic [POS_W-1:0]               pos_nxt;
  logic                           src_valid;
  logic signed [SAMPLE_WIDTH-1:0] src_value;
  logic [POS_W-1:0]               src_pos;
  logic                           take_new;

  always_comb begin
    if (ctl.flush) begin
      src_valid = 1'b0;
    end else if (ctl.drop) begin
      src_valid = nb_valid;
    end else begin
      src_valid = valid_r;
    end
    src_value = ctl.drop ? nb_value : value_r;
    src_pos   = ctl.drop ? nb_pos : pos_r;
  end

  // Values fall strictly from head to tail, so the slots not above the new
  // sample form a suffix; the first of them takes the new sample.
  assign kept      = src_valid && (src_value > new_value);
  assign take_new  = !kept && prev_kept;
  assign valid_nxt = kept || take_new;
  assign value_nxt = kept ? src_value : new_value;
  assign pos_nxt   = kept ? src_pos : new_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.wipe) begin
      valid_r <= 1'b0;
    end else if (ctl.step) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      value_r <= value_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign valid = valid_r;
  assign value = value_r;
  assign pos   = pos_r;

endmodule

[design/sliding_window_max.sv]
// Sliding window maximum: top level with control, counters and output register.
// Depends on swm_pkg and a row of swm_cell instances.
//
// Gives the largest of the last k signed samples, k taken from the window size
// register (0 reads as 1, values above WINDOW_MAX saturate). One input word is
// taken per clock cycle and its result, if any, appears in the next cycle: every
// queue slot compares its value with the new sample at once, so the whole queue
// update is registered together. No result comes until k samples have arrived since
// the last restart. Setting in_tuser restarts the sequence with that word, and a
// window size write restarts it as well. The input stalls only while a result
// waits in the output register and out_tready is low.
module sliding_window_max import swm_pkg::*; #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_W-1:0]                  cfg_data,   // window_size
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,   // sample, then zero fill
  input  logic                              in_tuser,   // restart
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata   // window_max, then zero fill
);

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int KW     = $clog2(WINDOW_MAX + 1);
  localparam int POS_W  = $clog2(2 * WINDOW_MAX);
  localparam int CW     = (KW > CFG_W) ? KW : CFG_W;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(2 * WINDOW_MAX - 1);

  logic [CFG_W-1:0]        window_size_r;
  logic [KW-1:0]           fill_r;
  logic [KW-1:0]           fill_nxt;
  logic [POS_W-1:0]        next_pos_r;
  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] out_data_r;

  logic [CW-1:0]           ws_ext;
  logic [KW-1:0]           k_eff;
  logic                    in_acc;
  logic                    cfg_acc;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [POS_W:0]          age_raw;
  logic [POS_W:0]          age;
  swm_ctl_t                ctl;

  logic [WINDOW_MAX-1:0]   cell_valid;
  logic [WINDOW_MAX-1:0]   cell_kept;
  logic signed [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
  logic [POS_W-1:0]        cell_pos [WINDOW_MAX];
  logic signed [SAMPLE_WIDTH-1:0] cell_value_nxt [WINDOW_MAX];

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign sample    = in_tdata[SAMPLE_WIDTH-1:0];

  always_comb begin
    ws_ext = CW'(window_size_r);
    if (ws_ext == '0) begin
      k_eff = KW'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      k_eff = KW'(WINDOW_MAX);
    end else begin
      k_eff = KW'(ws_ext);
    end
  end

  // Age of the head, with positions counted modulo twice the window depth.
  always_comb begin
    age_raw = {1'b0, next_pos_r} - {1'b0, cell_pos[0]};
    if (age_raw[POS_W]) begin
      age = age_raw + (POS_W+1)'(2 * WINDOW_MAX);
    end else begin
      age = age_raw;
    end
  end

  always_comb begin
    ctl.step  = in_acc;
    ctl.flush = in_tuser;
    ctl.drop  = !in_tuser && cell_valid[0] && (age >= (POS_W+1)'(k_eff));
    ctl.wipe  = cfg_acc;
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                           nb_valid;
    logic signed [SAMPLE_WIDTH-1:0] nb_value;
    logic [POS_W-1:0]               nb_pos;
    logic                           prev_kept;

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_value = '0;
      assign nb_pos   = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[i+1];
      assign nb_value = cell_value[i+1];
      assign nb_pos   = cell_pos[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_kept = 1'b1;
    end else begin : g_body
      assign prev_kept = cell_kept[i-1];
    end

    swm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .POS_W       (POS_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_value(sample),
      .new_pos  (in_tuser ? '0 : next_pos_r),
      .nb_valid (nb_valid),
      .nb_value (nb_value),
      .nb_pos   (nb_pos),
      .prev_kept(prev_kept),
      .valid    (cell_valid[i]),
      .value    (cell_value[i]),
      .pos      (cell_pos[i]),
      .kept     (cell_kept[i]),
      .value_nxt(cell_value_nxt[i])
    );
  end

  always_comb begin
    fill_nxt = in_tuser ? '0 : fill_r;
    if (fill_nxt < k_eff) begin
      fill_nxt = fill_nxt + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
      fill_r        <= '0;
      next_pos_r    <= '0;
    end else if (cfg_acc) begin
      window_size_r <= cfg_data;
      fill_r        <= '0;
      next_pos_r    <= '0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
      if (in_tuser) begin
        next_pos_r <= POS_W'(1);
      end else if (next_pos_r == POS_LAST) begin
        next_pos_r <= '0;
      end else begin
        next_pos_r <= next_pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= (fill_nxt >= k_eff);
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= cell_value_nxt[0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'(out_data_r);

`ifndef ASSERT_OFF
  // A window of one passes each sample straight to the output.
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (k_eff == KW'(1)) |=>
      out_valid_r && (out_data_r == $past(in_tdata[SAMPLE_WIDTH-1:0])))
    else $error("window of one did not pass the sample through");

  // Occupied slots always form an unbroken run from the head.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, cell_valid} + (WINDOW_MAX+1)'(1)))
    else $error("queue slots are not contiguous from the head");

  // The queue never holds more entries than the window is long.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) <= int'(k_eff))
    else $error("queue holds more entries than the window");

  // Every accepted word leaves at least its own sample in the queue.
  a_head_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_acc |=> cell_valid[0])
    else $error("queue empty after an accepted word");
`endif

endmodule
